>>> hw/rtl/stb_pkg.sv
// ----------------------------------------------------------------------------
// stb_pkg
// Types and constants shared by the software timer bank.
// ----------------------------------------------------------------------------
package stb_pkg;

    localparam int NUM_TIMERS  = 16;
    localparam int MAX_RESULTS = 16;
    localparam int IDX_W       = $clog2(NUM_TIMERS);
    localparam int CNT_W       = $clog2(NUM_TIMERS + 1);
    localparam logic [7:0] NO_ID = 8'd255;
    localparam logic [6:0] PERCENT_SCALE = 7'd100;

    typedef enum logic [3:0] {
        REQ_TICK      = 4'd0,
        REQ_CREATE    = 4'd1,
        REQ_ONESHOT   = 4'd2,
        REQ_RESET     = 4'd3,
        REQ_STOP      = 4'd4,
        REQ_START     = 4'd5,
        REQ_DESTROY   = 4'd6,
        REQ_REMAIN    = 4'd7,
        REQ_PROGRESS  = 4'd8,
        REQ_UPTIME    = 4'd9
    } t_req;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_FREE = 2'd1,
        ST_BAD     = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TK_RD,
        S_TK_EVAL,
        S_TK_DONE,
        S_OP_RD,
        S_OP_EXEC,
        S_DIV,
        S_OUT
    } t_state;

    // one timer's counter entry
    typedef struct packed {
        logic [31:0] count;
        logic [31:0] limit;
    } t_entry;

    typedef struct packed {
        logic        start;
        logic [39:0] num;
        logic [31:0] den;
    } t_div_req;

endpackage

>>> hw/rtl/software_timer_bank_unit.sv
// ----------------------------------------------------------------------------
// software_timer_bank_unit
// Bank of software timers with uptime counter; counts and limits in a synchronous RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid/o_stall carries one request (type, id, timeout).
//   Output channel o_valid/i_stall carries results; o_last marks the final
//   result of a request. A tick gives one result per expired timer (index
//   order) or a single "none" result; every other request gives one.
// Sequencing:
//   One request at a time. The counts and limits live in one RAM with a
//   registered read port; a tick walks every timer with a read then a
//   write-back (S_TK_RD, S_TK_EVAL) and waits on output stalls. Single
//   timer requests pass S_OP_RD, S_OP_EXEC and S_OUT; progress adds a pass
//   through the bit-serial divider.
// Reset:
//   Flags and uptime clear at once. The RAM is cleared by a sweep over all
//   NUM_TIMERS entries after reset, during which o_stall stays high.
// Stall:
//   A pending result sits in the output register until taken; the walk
//   waits there, so no result is lost.
// ----------------------------------------------------------------------------
module software_timer_bank_unit import stb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [3:0]  i_req_type,
    input  logic [7:0]  i_timer_id,
    input  logic [31:0] i_timeout,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_result_id,
    output logic [31:0] o_result_value,
    output logic        o_expired,
    output logic [1:0]  o_status,
    output logic        o_last
);
    t_entry r_mem [NUM_TIMERS];
    t_entry r_rd;
    logic [IDX_W-1:0] w_ra, w_wa;
    logic   w_we;
    t_entry w_wd;

    logic [NUM_TIMERS-1:0] r_en, n_en, r_run, n_run, r_os, n_os;
    logic [31:0] r_up, n_up;
    t_state r_st, n_st;
    logic [3:0]  r_req, n_req;
    logic [7:0]  r_id, n_id;
    logic [31:0] r_to, n_to;
    logic [CNT_W-1:0] r_idx, n_idx, r_clr, n_clr;
    logic [CNT_W-1:0] r_nres, n_nres;
    logic r_clr_busy, n_clr_busy;
    logic r_any, n_any;
    logic r_pend, n_pend;       // a tick result waiting for next fire check
    logic [IDX_W-1:0] r_pid, n_pid;
    logic r_ov, n_ov;
    logic [7:0]  r_oid, n_oid;
    logic [31:0] r_oval, n_oval;
    logic r_oexp, n_oexp, r_olast, n_olast;
    logic [1:0]  r_ost, n_ost;
    logic [IDX_W-1:0] w_free;
    logic w_has_free;
    logic w_valid_id;
    logic [IDX_W-1:0] w_id;
    logic [31:0] w_cnt;
    logic w_fire;
    logic [IDX_W-1:0] w_cur;
    logic w_in_acc, w_out_free;
    t_div_req w_div;
    logic w_div_done;
    logic [39:0] w_quot;

    stb_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_div),
        .o_done (w_div_done),
        .o_quot (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_wa] <= w_wd;
        r_rd <= r_mem[w_ra];
    end

    always_comb begin
        w_free = '0;
        w_has_free = 1'b0;
        for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
            if (!r_en[i]) begin
                w_free = IDX_W'(i);
                w_has_free = 1'b1;
            end
        end
    end

    assign w_valid_id = r_id < 8'(NUM_TIMERS);
    assign w_id       = r_id[IDX_W-1:0];
    assign w_cur      = r_idx[IDX_W-1:0];
    assign w_cnt      = (r_en[w_cur] && r_run[w_cur]) ? r_rd.count + 32'd1 : r_rd.count;
    assign w_fire     = r_en[w_cur] && (w_cnt >= r_rd.limit);
    assign w_out_free = !r_ov || !i_stall;
    assign o_stall    = (r_st != S_IDLE) || r_clr_busy || r_ov;
    assign w_in_acc   = i_valid && !o_stall;

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE:    if (w_in_acc) n_st = (t_req'(i_req_type) == REQ_TICK) ? S_TK_RD : S_OP_RD;
            S_TK_RD:   n_st = S_TK_EVAL;
            S_TK_EVAL: begin
                if (w_out_free || !(w_fire && r_nres != CNT_W'(0) && r_pend)) begin
                    if (r_idx == CNT_W'(NUM_TIMERS - 1)) n_st = S_TK_DONE;
                    else n_st = S_TK_RD;
                end
            end
            S_TK_DONE: if (w_out_free) n_st = S_IDLE;
            S_OP_RD:   n_st = S_OP_EXEC;
            S_OP_EXEC: n_st = (t_req'(r_req) == REQ_PROGRESS && w_valid_id &&
                              r_rd.limit != 0 && r_rd.count != 0) ? S_DIV : S_OUT;
            S_DIV:     if (w_div_done) n_st = S_OUT;
            S_OUT:     if (w_out_free) n_st = S_IDLE;
            default:   n_st = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_en = r_en; n_run = r_run; n_os = r_os; n_up = r_up;
        n_req = r_req; n_id = r_id; n_to = r_to; n_idx = r_idx;
        n_clr = r_clr; n_clr_busy = r_clr_busy; n_nres = r_nres;
        n_any = r_any; n_pend = r_pend; n_pid = r_pid;
        n_ov = r_ov; n_oid = r_oid; n_oval = r_oval; n_oexp = r_oexp;
        n_olast = r_olast; n_ost = r_ost;
        w_ra = w_id; w_wa = w_cur; w_we = 1'b0; w_wd = r_rd;
        w_div = '0;
        if (r_ov && !i_stall) n_ov = 1'b0;
        if (r_clr_busy) begin
            w_we = 1'b1; w_wa = r_clr[IDX_W-1:0]; w_wd = '0;
            n_clr = r_clr + CNT_W'(1);
            if (r_clr == CNT_W'(NUM_TIMERS - 1)) n_clr_busy = 1'b0;
        end
        case (r_st)
            S_IDLE: if (w_in_acc) begin
                n_req = i_req_type; n_id = i_timer_id; n_to = i_timeout;
                n_idx = '0; n_nres = CNT_W'(MAX_RESULTS); n_any = 1'b0; n_pend = 1'b0;
            end
            S_TK_RD: w_ra = w_cur;
            S_TK_EVAL: begin
                // keep the current entry on the read port while waiting
                w_ra = w_cur;
                // a fire with a result already pending must wait until the output register frees
                if (w_out_free || !(w_fire && r_nres != CNT_W'(0) && r_pend)) begin
                    w_we = 1'b1;
                    w_wd.count = w_fire ? 32'd0 : w_cnt;
                    w_wd.limit = r_rd.limit;
                    if (w_fire) begin
                        if (r_os[w_cur]) n_en[w_cur] = 1'b0;
                        n_any = 1'b1;
                        if (r_nres != CNT_W'(0)) begin
                            if (r_pend) begin
                                n_ov = 1'b1; n_olast = 1'b0;
                                n_oid = 8'(r_pid); n_oval = '0; n_oexp = 1'b1;
                                n_ost = ST_OK;
                            end
                            n_pend = 1'b1;
                            n_pid = w_cur;
                            n_nres = r_nres - CNT_W'(1);
                        end
                    end
                    n_idx = r_idx + CNT_W'(1);
                    w_ra = n_idx[IDX_W-1:0];
                end
            end
            S_TK_DONE: if (w_out_free) begin
                n_ov = 1'b1; n_olast = 1'b1;
                n_up = r_up + 32'd1;
                if (!r_any) begin
                    n_oid = NO_ID; n_oval = '0; n_oexp = 1'b0; n_ost = ST_OK;
                end else begin
                    n_oid = 8'(r_pid); n_oval = '0; n_oexp = 1'b1; n_ost = ST_OK;
                end
            end
            S_OP_EXEC: begin
                n_oid = r_id; n_oval = '0; n_oexp = 1'b0; n_ost = ST_OK;
                w_wa = w_id;
                case (t_req'(r_req))
                    REQ_CREATE, REQ_ONESHOT: begin
                        if (t_req'(r_req) == REQ_ONESHOT && w_valid_id && r_en[w_id]) begin
                            w_wa = w_id;
                        end else begin
                            w_wa = w_free;
                        end
                        if (!(t_req'(r_req) == REQ_ONESHOT && w_valid_id && r_en[w_id])
                            && !w_has_free) begin
                            n_oid = NO_ID; n_ost = ST_NO_FREE;
                        end else begin
                            w_we = 1'b1; w_wd.count = '0; w_wd.limit = r_to;
                            n_en[w_wa] = 1'b1;
                            n_run[w_wa] = (t_req'(r_req) == REQ_ONESHOT);
                            n_os[w_wa] = (t_req'(r_req) == REQ_ONESHOT);
                            n_oid = 8'(w_wa);
                        end
                    end
                    REQ_UPTIME: begin
                        n_oid = NO_ID; n_oval = r_up;
                    end
                    REQ_TICK: ;
                    default: begin
                        if (r_req > REQ_UPTIME || !w_valid_id) begin
                            n_oid = NO_ID; n_ost = ST_BAD;
                        end else begin
                            case (t_req'(r_req))
                                REQ_RESET: if (r_to == 0) n_ost = ST_BAD;
                                    else begin
                                        w_we = 1'b1; w_wd.count = '0; w_wd.limit = r_to;
                                    end
                                REQ_STOP:    n_run[w_id] = 1'b0;
                                REQ_START:   if (r_rd.limit == 0) n_ost = ST_BAD;
                                             else n_run[w_id] = 1'b1;
                                REQ_DESTROY: n_en[w_id] = 1'b0;
                                REQ_REMAIN:  if (r_rd.limit > r_rd.count)
                                                 n_oval = r_rd.limit - r_rd.count;
                                default: begin
                                    w_div.start = (r_rd.limit != 0 && r_rd.count != 0);
                                    w_div.num = ({8'd0, r_rd.count} + 40'd1) * 40'(PERCENT_SCALE)
                                                + {9'd0, r_rd.limit[31:1]};
                                    w_div.den = r_rd.limit;
                                end
                            endcase
                        end
                    end
                endcase
            end
            S_DIV: if (w_div_done)
                n_oval = (w_quot[39:32] != 0) ? 32'hFFFF_FFFF : w_quot[31:0];
            S_OUT: if (w_out_free) begin
                n_ov = 1'b1; n_olast = 1'b1;
            end
            default: ;
        endcase
        // clear sweep has the port; no request runs then
        if (r_clr_busy) begin
            w_we = 1'b1; w_wa = r_clr[IDX_W-1:0]; w_wd = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_en <= '0; r_run <= '0; r_os <= '0; r_up <= '0;
            r_clr <= '0; r_clr_busy <= 1'b1; r_ov <= 1'b0; r_pend <= 1'b0;
            r_idx <= '0; r_nres <= '0; r_any <= 1'b0;
        end else begin
            r_st <= n_st; r_en <= n_en; r_run <= n_run; r_os <= n_os; r_up <= n_up;
            r_clr <= n_clr; r_clr_busy <= n_clr_busy; r_ov <= n_ov; r_pend <= n_pend;
            r_idx <= n_idx; r_nres <= n_nres; r_any <= n_any;
        end
        r_req <= n_req; r_id <= n_id; r_to <= n_to; r_pid <= n_pid;
        r_oid <= n_oid; r_oval <= n_oval; r_oexp <= n_oexp;
        r_olast <= n_olast; r_ost <= n_ost;
    end

    assign o_valid        = r_ov;
    assign o_result_id    = r_oid;
    assign o_result_value = r_oval;
    assign o_expired      = r_oexp;
    assign o_status       = r_ost;
    assign o_last         = r_olast;

`ifndef SYNTHESIS
    a_no_req_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> r_st == S_IDLE)
        else $error("request during clear sweep");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_stall && r_olast) |=> r_st == S_IDLE)
        else $error("last result before request done");
    a_uptime_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != S_TK_DONE) |=> $stable(r_up))
        else $error("uptime moved outside tick");
`endif
endmodule

>>> hw/rtl/stb_div.sv
// ----------------------------------------------------------------------------
// stb_div
// Radix-2 restoring divider, one quotient bit per cycle, 40 by 32 bits.
// ----------------------------------------------------------------------------
module stb_div import stb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_div_req    i_req,
    output logic        o_done,
    output logic [39:0] o_quot
);
    logic [39:0] r_quot, n_quot;
    logic [32:0] r_rem, n_rem;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy, r_done, n_done;
    logic [31:0] r_den;
    logic [32:0] w_sh;

    always_comb begin
        n_quot = r_quot;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_sh   = {r_rem[31:0], r_quot[39]};
        if (i_req.start) begin
            n_quot = i_req.num;
            n_rem  = '0;
            n_cnt  = 6'd40;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_sh >= {1'b0, r_den}) begin
                n_rem  = w_sh - {1'b0, r_den};
                n_quot = {r_quot[38:0], 1'b1};
            end else begin
                n_rem  = w_sh;
                n_quot = {r_quot[38:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        if (i_req.start) r_den <= i_req.den;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

`ifndef SYNTHESIS
    a_cnt_zero_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> !$past(r_busy) || r_done || $past(i_req.start))
        else $error("divider idle with count pending");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("divider done held");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("done without busy");
`endif
endmodule
